[sv/lrrs_pkg.sv]
package lrrs_pkg;

    localparam int ROW_W = 64;
    localparam int CNT_W = 7;
    localparam int SYM_W = 6;

    // scores of one row against the failed and lost symbols
    typedef struct packed {
        logic             cand;
        logic [ROW_W-1:0] rest;
        logic [CNT_W-1:0] weight;
        logic [CNT_W-1:0] lost;
    } score_t;

    // result of one repair job
    typedef struct packed {
        logic [ROW_W-1:0] helper_mask;
        logic             base_station_used;
        logic             no_candidate;
    } result_t;

    // population count as a six-level adder tree
    function automatic logic [CNT_W-1:0] ones64(input logic [ROW_W-1:0] v);
        logic [CNT_W-1:0] s [ROW_W];
        for (int i = 0; i < ROW_W; i++)
        begin
            s[i] = {{(CNT_W-1){1'b0}}, v[i]};
        end
        for (int lvl = 0; lvl < 6; lvl++)
        begin
            for (int i = 0; i < (32 >> lvl); i++)
            begin
                s[i] = s[2*i] + s[2*i+1];
            end
        end
        return s[0];
    endfunction

endpackage

[sv/lrrs_score.sv]
module lrrs_score (
    input  logic [lrrs_pkg::ROW_W-1:0] row,
    input  logic [lrrs_pkg::SYM_W-1:0] failed,
    input  logic [lrrs_pkg::ROW_W-1:0] lost,
    output lrrs_pkg::score_t           sc
);
    import lrrs_pkg::*;

    logic [ROW_W-1:0] fbit;
    logic [ROW_W-1:0] rest;

    // candidate test and remainder without the failed symbol
    assign fbit = {{(ROW_W-1){1'b0}}, 1'b1} << failed;
    assign rest = row & ~fbit;

    // weight and lost count of the remainder
    always_comb
    begin
        sc.cand   = |(row & fbit);
        sc.rest   = rest;
        sc.weight = ones64(rest);
        sc.lost   = ones64(rest & lost);
    end

endmodule

[sv/lrrs_track.sv]
module lrrs_track (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic              last,
    input  lrrs_pkg::score_t  sc,
    output lrrs_pkg::result_t res
);
    import lrrs_pkg::*;

    logic             seen_cand_reg, seen_cand_next;
    logic             seen_nz_reg, seen_nz_next;
    logic             seen_clean_reg, seen_clean_next;
    logic [CNT_W-1:0] clean_w_reg, clean_w_next;
    logic [ROW_W-1:0] clean_m_reg, clean_m_next;
    logic [CNT_W-1:0] fb_l_reg, fb_l_next;
    logic [CNT_W-1:0] fb_w_reg, fb_w_next;
    logic [ROW_W-1:0] fb_m_reg, fb_m_next;
    logic             clean_upd;
    logic             fb_upd;

    // strict improvement tests, earliest row wins a tie
    assign clean_upd = sc.cand && (sc.lost == '0)
                       && (!seen_clean_reg || (sc.weight < clean_w_reg));
    assign fb_upd    = sc.cand && (!seen_cand_reg || (sc.lost < fb_l_reg)
                       || ((sc.lost == fb_l_reg) && (sc.weight < fb_w_reg)));

    // running bests including the current row
    always_comb
    begin
        seen_cand_next  = seen_cand_reg | sc.cand;
        seen_nz_next    = seen_nz_reg | (sc.cand & (|sc.rest));
        seen_clean_next = seen_clean_reg | clean_upd;
        clean_w_next    = clean_upd ? sc.weight : clean_w_reg;
        clean_m_next    = clean_upd ? sc.rest : clean_m_reg;
        fb_l_next       = fb_upd ? sc.lost : fb_l_reg;
        fb_w_next       = fb_upd ? sc.weight : fb_w_reg;
        fb_m_next       = fb_upd ? sc.rest : fb_m_reg;
    end

    // job result from the updated bests
    always_comb
    begin
        res.no_candidate = !seen_cand_next;
        if (!seen_cand_next)
        begin
            res.helper_mask       = '0;
            res.base_station_used = 1'b1;
        end
        else if (seen_clean_next && seen_nz_next)
        begin
            res.helper_mask       = clean_m_next;
            res.base_station_used = 1'b0;
        end
        else
        begin
            res.helper_mask       = fb_m_next;
            res.base_station_used = 1'b1;
        end
    end

    // job state, cleared after the last row
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_cand_reg  <= 1'b0;
            seen_nz_reg    <= 1'b0;
            seen_clean_reg <= 1'b0;
            clean_w_reg    <= '0;
            clean_m_reg    <= '0;
            fb_l_reg       <= '0;
            fb_w_reg       <= '0;
            fb_m_reg       <= '0;
        end
        else if (step)
        begin
            if (last)
            begin
                seen_cand_reg  <= 1'b0;
                seen_nz_reg    <= 1'b0;
                seen_clean_reg <= 1'b0;
                clean_w_reg    <= '0;
                clean_m_reg    <= '0;
                fb_l_reg       <= '0;
                fb_w_reg       <= '0;
                fb_m_reg       <= '0;
            end
            else
            begin
                seen_cand_reg  <= seen_cand_next;
                seen_nz_reg    <= seen_nz_next;
                seen_clean_reg <= seen_clean_next;
                clean_w_reg    <= clean_w_next;
                clean_m_reg    <= clean_m_next;
                fb_l_reg       <= fb_l_next;
                fb_w_reg       <= fb_w_next;
                fb_m_reg       <= fb_m_next;
            end
        end
    end

endmodule

[sv/ldpc_repair_row_selector_top.sv]
// LDPC repair row selector.
// Matrix rows enter on the input channel (row_bits, last_row) as requests
// with in_valid/in_ready. Each row holding the failed symbol is scored by
// weight and lost-symbol count against running bests. When the row flagged
// last_row has been scored, one result request (helper_mask,
// base_station_used, no_candidate) leaves on out_valid/out_ready; other
// rows produce nothing.
// A last row is scored from the input register straight into the output
// register. Throughput: one row per cycle while no last row waits for the
// output register; the per-row popcounts and compares sit between the
// input register and the job-state/result registers.
// A stalled receiver holds the result; rows that are not last still pass
// through, and a last row waits in the input register until the output
// register is free, which then holds in_ready low.
// Configuration: the user makes APB writes to failed_symbol (address 0)
// and lost_mask (address 8) only while the block is idle; not enforced.
// Reset clears both registers, the job state and all valid flags.
module ldpc_repair_row_selector_top #(
    parameter int NUM_SYMBOLS = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [3:0]                  paddr,
    input  logic [63:0]                 pwdata,
    output logic [63:0]                 prdata,
    output logic                        pready,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [lrrs_pkg::ROW_W-1:0]  row_bits,
    input  logic                        last_row,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [lrrs_pkg::ROW_W-1:0]  helper_mask,
    output logic                        base_station_used,
    output logic                        no_candidate
);
    import lrrs_pkg::*;

    localparam logic ADDR_FAILED = 1'b0;
    localparam logic ADDR_LOST   = 1'b1;
    localparam logic [ROW_W-1:0] COL_MASK = (NUM_SYMBOLS >= ROW_W) ? '1
        : ((({{(ROW_W-1){1'b0}}, 1'b1}) << NUM_SYMBOLS) - {{(ROW_W-1){1'b0}}, 1'b1});

    logic [SYM_W-1:0] failed_reg;
    logic [ROW_W-1:0] lost_reg;
    logic             s1_valid_reg;
    logic [ROW_W-1:0] s1_row_reg;
    logic             s1_last_reg;
    logic             out_valid_reg;
    result_t          res_reg;
    result_t          res;
    score_t           sc;
    logic             advance;
    logic             in_take;
    logic             cfg_wr;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        unique case (paddr[3])
            ADDR_FAILED: prdata = {{(64-SYM_W){1'b0}}, failed_reg};
            ADDR_LOST:   prdata = lost_reg;
            default:     prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            failed_reg <= '0;
            lost_reg   <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3])
                ADDR_FAILED: failed_reg <= pwdata[SYM_W-1:0];
                ADDR_LOST:   lost_reg   <= pwdata;
                default:     ;
            endcase
        end
    end

    // handshake: a last row needs the output register free
    assign advance  = s1_valid_reg && (!s1_last_reg || !out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;
    assign in_take  = in_valid && in_ready;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_row_reg  <= row_bits & COL_MASK;
            s1_last_reg <= last_row;
        end
    end

    // row scoring and job tracking
    lrrs_score u_score (
        .row    (s1_row_reg),
        .failed (failed_reg),
        .lost   (lost_reg & COL_MASK),
        .sc     (sc)
    );

    lrrs_track u_track (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .last  (s1_last_reg),
        .sc    (sc),
        .res   (res)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && s1_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_last_reg)
        begin
            res_reg <= res;
        end
    end

    assign out_valid         = out_valid_reg;
    assign helper_mask       = res_reg.helper_mask;
    assign base_station_used = res_reg.base_station_used;
    assign no_candidate      = res_reg.no_candidate;

endmodule

[dv/testbench.sv]
module testbench;

    import lrrs_pkg::*;

    localparam int NSYM = 64;
    localparam int SETTLE = 4;
    localparam int LIMIT = 400000;
    localparam int JOB_ITEMS = 66;

    localparam logic [3:0] REG_FAILED_SYMBOL = 4'd0;
    localparam logic [3:0] REG_LOST_MASK = 4'd8;

    typedef enum logic [1:0] {STEP_ROW, STEP_FAILED, STEP_LOST} step_kind_t;

    typedef struct {
        step_kind_t  kind;
        logic [63:0] data;
        logic        last;
        logic        pin;
        result_t     want;
    } dir_step_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_ready;
    logic [63:0] row_bits;
    logic        last_row;
    logic        out_valid;
    logic        out_ready;
    logic [63:0] helper_mask;
    logic        base_station_used;
    logic        no_candidate;

    // configuration copy and per-job scores of the selector model
    logic [5:0]  cfg_failed;
    logic [63:0] cfg_lost;
    bit          job_cand;
    bit          job_nonzero;
    bit          job_clean;
    int          clean_w;
    logic [63:0] clean_mask;
    int          fb_lost;
    int          fb_w;
    logic [63:0] fb_mask;

    result_t     pending_results [$];
    dir_step_t   dir_steps [$];
    int          send_idle_pct;
    int          stall_pct;
    int          errors;
    int          cycle_count;

    ldpc_repair_row_selector_top #(
        .NUM_SYMBOLS(NSYM)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .row_bits(row_bits),
        .last_row(last_row),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .helper_mask(helper_mask),
        .base_station_used(base_station_used),
        .no_candidate(no_candidate)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // receiver back-pressure
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // compare each result request with the oldest expectation
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result helper_mask %h bsu %b nc %b", $time,
                         helper_mask, base_station_used, no_candidate);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (helper_mask !== want.helper_mask)
                begin
                    $display("%0t: helper_mask expected %h got %h", $time,
                             want.helper_mask, helper_mask);
                    errors++;
                end
                if (base_station_used !== want.base_station_used)
                begin
                    $display("%0t: base_station_used expected %b got %b", $time,
                             want.base_station_used, base_station_used);
                    errors++;
                end
                if (no_candidate !== want.no_candidate)
                begin
                    $display("%0t: no_candidate expected %b got %b", $time,
                             want.no_candidate, no_candidate);
                    errors++;
                end
            end
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [63:0] sparse_bits(input int k);
        logic [63:0] v;
        v = '0;
        for (int i = 0; i < k; i++)
        begin
            v[$urandom_range(63)] = 1'b1;
        end
        return v;
    endfunction

    // clear the running bests of a repair job
    task automatic clear_scores();
        job_cand = 1'b0;
        job_nonzero = 1'b0;
        job_clean = 1'b0;
        clean_w = 0;
        clean_mask = '0;
        fb_lost = 0;
        fb_w = 0;
        fb_mask = '0;
    endtask

    // score one accepted row; a last row yields the selected helper set
    task automatic select_row(input logic [63:0] rb, input logic last,
                              output result_t res);
        logic [63:0] cols;
        logic [63:0] row;
        logic [63:0] fbit;
        logic [63:0] rest;
        int          w;
        int          l;
        cols = (NSYM >= 64) ? {64{1'b1}} : ((64'd1 << NSYM) - 64'd1);
        row = rb & cols;
        fbit = 64'd1 << cfg_failed;
        res = '0;
        if ((row & fbit) != 0)
        begin
            rest = row & ~fbit;
            w = $countones(rest);
            l = $countones(rest & cfg_lost & cols);
            if (rest != 0)
                job_nonzero = 1'b1;
            if (l == 0 && (!job_clean || w < clean_w))
            begin
                job_clean = 1'b1;
                clean_w = w;
                clean_mask = rest;
            end
            if (!job_cand || l < fb_lost || (l == fb_lost && w < fb_w))
            begin
                fb_lost = l;
                fb_w = w;
                fb_mask = rest;
            end
            job_cand = 1'b1;
        end
        if (last)
        begin
            if (!job_cand)
            begin
                res.helper_mask = '0;
                res.base_station_used = 1'b1;
                res.no_candidate = 1'b1;
            end
            else if (job_clean && job_nonzero)
            begin
                res.helper_mask = clean_mask;
                res.base_station_used = 1'b0;
                res.no_candidate = 1'b0;
            end
            else
            begin
                res.helper_mask = fb_mask;
                res.base_station_used = 1'b1;
                res.no_candidate = 1'b0;
            end
            clear_scores();
        end
    endtask

    // offer one row request, with random idle cycles ahead of it
    task automatic send_row(input logic [63:0] rb, input logic last,
                            input logic pin, input result_t pinned);
        result_t res;
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        row_bits <= rb;
        last_row <= last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        select_row(rb, last, res);
        if (last)
            pending_results = {pending_results, (pin ? pinned : res)};
    endtask

    // hold rows back until every result is out and the pipeline is empty
    task automatic wait_quiet();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic apb_write(input logic [3:0] addr, input logic [63:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (addr == REG_FAILED_SYMBOL)
            cfg_failed = data[5:0];
        else if (addr == REG_LOST_MASK)
            cfg_lost = data;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    task automatic add_step(input step_kind_t kind, input logic [63:0] data,
                            input int last, input int pin,
                            input logic [63:0] mask, input int bsu,
                            input int nc);
        dir_step_t s;
        s.kind = kind;
        s.data = data;
        s.last = last[0];
        s.pin = pin[0];
        s.want.helper_mask = mask;
        s.want.base_station_used = bsu[0];
        s.want.no_candidate = nc[0];
        dir_steps = {dir_steps, s};
    endtask

    // random row: mostly sparse rows around the failed symbol, some noise
    function automatic logic [63:0] pick_row(input bit noise);
        logic [63:0] r;
        int          mode;
        mode = $urandom_range(9);
        if (noise || mode == 0)
            r = rand64();
        else if (mode == 1)
            r = '0;
        else if (mode == 2)
            r = '1;
        else
            r = sparse_bits($urandom_range(0, 6));
        if (!noise)
            r[cfg_failed] = ($urandom_range(3) != 0);
        return r;
    endfunction

    // well-formed repair jobs, each closed by a last row
    task automatic random_jobs(input int n);
        int      sent;
        int      len;
        bit      noise;
        result_t none;
        sent = 0;
        none = '0;
        while (sent < n)
        begin
            len = ($urandom_range(9) == 0) ? $urandom_range(12, 24) : $urandom_range(1, 6);
            noise = ($urandom_range(9) == 0);
            for (int j = 0; j < len; j++)
            begin
                send_row(pick_row(noise), (j == len - 1), 1'b0, none);
                sent++;
            end
        end
    endtask

    initial
    begin
        logic [63:0] lost_val;
        logic [5:0]  failed_val;
        errors = 0;
        cycle_count = 0;
        send_idle_pct = 8;
        stall_pct = 62;
        cfg_failed = '0;
        cfg_lost = '0;
        clear_scores();
        rst_n = 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        in_valid <= 1'b0;
        row_bits <= '0;
        last_row <= 1'b0;
        out_ready <= 1'b0;

        // directed rows: empty job, full row, empty candidate, ties, fallback
        add_step(STEP_ROW, 64'h0, 1, 1, 64'h0, 1, 1);
        add_step(STEP_ROW, 64'hFFFF_FFFF_FFFF_FFFF, 1, 1, 64'hFFFF_FFFF_FFFF_FFFE, 0, 0);
        add_step(STEP_ROW, 64'h1, 1, 1, 64'h0, 1, 0);
        add_step(STEP_FAILED, 64'd63, 0, 0, 64'h0, 0, 0);
        add_step(STEP_LOST, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 64'h0, 0, 0);
        add_step(STEP_ROW, 64'h8000_0000_0000_0003, 0, 0, 64'h0, 0, 0);
        add_step(STEP_ROW, 64'h8000_0000_0000_0010, 0, 0, 64'h0, 0, 0);
        add_step(STEP_ROW, 64'h8000_0000_0000_0020, 1, 1, 64'h10, 1, 0);
        add_step(STEP_ROW, 64'hFFFF_FFFF_FFFF_FFFF, 1, 1, 64'h7FFF_FFFF_FFFF_FFFF, 1, 0);
        add_step(STEP_LOST, 64'hF0, 0, 0, 64'h0, 0, 0);
        add_step(STEP_ROW, 64'h8000_0000_0000_0F00, 0, 0, 64'h0, 0, 0);
        add_step(STEP_ROW, 64'h8000_0000_0000_0003, 0, 0, 64'h0, 0, 0);
        add_step(STEP_ROW, 64'h8000_0000_0000_000C, 0, 0, 64'h0, 0, 0);
        add_step(STEP_ROW, 64'h8000_0000_0000_0010, 0, 0, 64'h0, 0, 0);
        add_step(STEP_ROW, 64'h7FFF_FFFF_FFFF_FFFF, 1, 1, 64'h3, 0, 0);
        add_step(STEP_FAILED, 64'd0, 0, 0, 64'h0, 0, 0);
        add_step(STEP_ROW, 64'h1, 0, 0, 64'h0, 0, 0);
        add_step(STEP_ROW, 64'h11, 1, 0, 64'h0, 0, 0);
        // failed symbol moved in the middle of a job
        add_step(STEP_ROW, 64'h3, 0, 0, 64'h0, 0, 0);
        add_step(STEP_FAILED, 64'd5, 0, 0, 64'h0, 0, 0);
        add_step(STEP_ROW, 64'h21, 1, 0, 64'h0, 0, 0);
        add_step(STEP_LOST, 64'h0, 0, 0, 64'h0, 0, 0);
        add_step(STEP_ROW, 64'h0, 0, 0, 64'h0, 0, 0);
        add_step(STEP_ROW, 64'h20, 1, 1, 64'h0, 1, 0);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_steps[i])
        begin
            case (dir_steps[i].kind)
                STEP_ROW:
                    send_row(dir_steps[i].data, dir_steps[i].last, dir_steps[i].pin,
                             dir_steps[i].want);
                STEP_FAILED:
                begin
                    wait_quiet();
                    apb_write(REG_FAILED_SYMBOL, dir_steps[i].data);
                end
                default:
                begin
                    wait_quiet();
                    apb_write(REG_LOST_MASK, dir_steps[i].data);
                end
            endcase
        end

        // random jobs under three idle profiles, four settings each
        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = (ph == 0) ? 8 : (ph == 1) ? 62 : 0;
            stall_pct = (ph == 0) ? 62 : (ph == 1) ? 8 : 0;
            for (int seg = 0; seg < 4; seg++)
            begin
                case (seg)
                    0:
                    begin
                        failed_val = 6'd0;
                        lost_val = '0;
                    end
                    1:
                    begin
                        failed_val = 6'($urandom_range(63));
                        lost_val = sparse_bits($urandom_range(1, 5));
                    end
                    2:
                    begin
                        failed_val = 6'($urandom_range(63));
                        lost_val = rand64();
                    end
                    default:
                    begin
                        failed_val = 6'd63;
                        lost_val = '1;
                    end
                endcase
                wait_quiet();
                apb_write(REG_FAILED_SYMBOL, {58'd0, failed_val});
                apb_write(REG_LOST_MASK, lost_val);
                random_jobs(JOB_ITEMS);
            end
        end

        // drain and finish
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

[files.f]
sv/lrrs_pkg.sv
sv/lrrs_score.sv
sv/lrrs_track.sv
sv/ldpc_repair_row_selector_top.sv
dv/testbench.sv
